>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the ellipse rasterizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked only while the reset is released.
`define MER_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked only while the reset is released.
`define MER_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> hw/rtl/mer_pkg.sv
// Shared types and constants of the midpoint ellipse rasterizer.
`default_nettype none
package mer_pkg;

    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 10;

    localparam logic [1:0] LAST_PT = 2'd3;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_RX,
        OP_SQ_RY,
        OP_RX2_RY,
        OP_INIT1,
        OP_ROUND,
        OP_R1_MOVE,
        OP_R1_DEC,
        OP_SQ_TX,
        OP_MUL_TX2,
        OP_SQ_TY,
        OP_MUL_TY2,
        OP_MUL_RR,
        OP_ACC_SUB,
        OP_R2_MOVE,
        OP_R2_DEC
    } t_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_RX,
        ST_SQ_RY,
        ST_RX2_RY,
        ST_INIT1,
        ST_ROUND1,
        ST_R1_MOVE,
        ST_R1_DEC,
        ST_SQ_TX,
        ST_MUL_TX2,
        ST_SQ_TY,
        ST_MUL_TY2,
        ST_MUL_RR,
        ST_ACC_SUB,
        ST_ROUND2,
        ST_R2_MOVE,
        ST_R2_DEC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_op        op;
        logic [1:0] pt;
    } t_dp_cmd;

    typedef struct packed {
        logic in_r1;
        logic in_r2;
        logic shape_done;
    } t_dp_status;

endpackage
`default_nettype wire

>>> hw/rtl/mer_datapath.sv
// Datapath of the ellipse rasterizer: shared multiplier, slopes, decision and point output.
`default_nettype none
module mer_datapath #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire mer_pkg::t_dp_cmd              i_cmd,
    input  wire logic signed [COORD_BITS-1:0]  i_center_x,
    input  wire logic signed [COORD_BITS-1:0]  i_center_y,
    input  wire logic        [RADIUS_BITS-1:0] i_radius_x,
    input  wire logic        [RADIUS_BITS-1:0] i_radius_y,
    output mer_pkg::t_dp_status                o_status,
    output logic signed [COORD_BITS:0]         o_pixel_x,
    output logic signed [COORD_BITS:0]         o_pixel_y
);

    localparam int R       = RADIUS_BITS;
    localparam int XW      = R + 1;
    localparam int TX_W    = R + 2;
    localparam int SQ_W    = 2 * R;
    localparam int MB_W    = 2 * R + 4;
    localparam int PROD_W  = 4 * R + 4;
    localparam int SLOPE_W = 3 * R + 3;
    localparam int DEC_W   = 4 * R + 7;
    localparam int SUM_W   = ((COORD_BITS > XW) ? COORD_BITS : XW) + 1;

    logic signed [COORD_BITS-1:0] r_cx, r_cy;
    logic        [R-1:0]          r_rx, r_ry;
    logic        [SQ_W-1:0]       r_rx2, r_ry2;
    logic        [XW-1:0]         r_x;
    logic        [R-1:0]          r_y;
    logic signed [SLOPE_W-1:0]    r_px, r_py;
    logic signed [DEC_W-1:0]      r_dec, r_acc;
    logic        [PROD_W-1:0]     r_prod;
    logic                         r_r2;

    logic [SQ_W-1:0]   mul_a;
    logic [MB_W-1:0]   mul_b;
    logic [PROD_W-1:0] prod_full;
    logic [TX_W-1:0]   tx;
    logic [R-1:0]      ty;

    logic signed [SLOPE_W-1:0] ry2_x2, rx2_x2, py_init;
    logic signed [DEC_W-1:0]   ry2_d, rx2_d, px_d, py_d, prod_d, prod_x4;
    logic signed [DEC_W-1:0]   init1_sum, rounded;
    logic        [DEC_W-1:0]   mag, quarter;
    logic                      d_neg, d_pos;

    logic signed [SUM_W-1:0]   cx_s, cy_s, x_s, y_s, sum_x, sum_y;

    assign tx = {r_x, 1'b0} + TX_W'(1);
    assign ty = r_y - R'(1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            mer_pkg::OP_SQ_RX: begin
                mul_a = {{(SQ_W-R){1'b0}}, r_rx};
                mul_b = {{(MB_W-R){1'b0}}, r_rx};
            end
            mer_pkg::OP_SQ_RY: begin
                mul_a = {{(SQ_W-R){1'b0}}, r_ry};
                mul_b = {{(MB_W-R){1'b0}}, r_ry};
            end
            mer_pkg::OP_RX2_RY: begin
                mul_a = r_rx2;
                mul_b = {{(MB_W-R){1'b0}}, r_ry};
            end
            mer_pkg::OP_SQ_TX: begin
                mul_a = {{(SQ_W-TX_W){1'b0}}, tx};
                mul_b = {{(MB_W-TX_W){1'b0}}, tx};
            end
            mer_pkg::OP_MUL_TX2: begin
                mul_a = r_ry2;
                mul_b = r_prod[MB_W-1:0];
            end
            mer_pkg::OP_SQ_TY: begin
                mul_a = {{(SQ_W-R){1'b0}}, ty};
                mul_b = {{(MB_W-R){1'b0}}, ty};
            end
            mer_pkg::OP_MUL_TY2: begin
                mul_a = r_rx2;
                mul_b = r_prod[MB_W-1:0];
            end
            mer_pkg::OP_MUL_RR: begin
                mul_a = r_rx2;
                mul_b = {{(MB_W-SQ_W){1'b0}}, r_ry2};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = {{(PROD_W-SQ_W){1'b0}}, mul_a} * {{(PROD_W-MB_W){1'b0}}, mul_b};

    assign ry2_x2  = {{(SLOPE_W-SQ_W-1){1'b0}}, r_ry2, 1'b0};
    assign rx2_x2  = {{(SLOPE_W-SQ_W-1){1'b0}}, r_rx2, 1'b0};
    assign py_init = {{(SLOPE_W-3*R-1){1'b0}}, r_prod[3*R-1:0], 1'b0};

    assign ry2_d   = {{(DEC_W-SQ_W){1'b0}}, r_ry2};
    assign rx2_d   = {{(DEC_W-SQ_W){1'b0}}, r_rx2};
    assign px_d    = {{(DEC_W-SLOPE_W){r_px[SLOPE_W-1]}}, r_px};
    assign py_d    = {{(DEC_W-SLOPE_W){r_py[SLOPE_W-1]}}, r_py};
    assign prod_d  = {{(DEC_W-PROD_W){1'b0}}, r_prod};
    assign prod_x4 = {{(DEC_W-PROD_W-2){1'b0}}, r_prod, 2'b00};

    // 4*ry^2 - 4*rx^2*ry + rx^2, a quarter-unit value rounded afterwards.
    assign init1_sum = {{(DEC_W-SQ_W-2){1'b0}}, r_ry2, 2'b00}
                     - {{(DEC_W-3*R-2){1'b0}}, r_prod[3*R-1:0], 2'b00}
                     + rx2_d;

    // Quarter rounded to nearest, halves away from zero.
    assign mag     = r_acc[DEC_W-1] ? DEC_W'(-r_acc) : DEC_W'(r_acc);
    assign quarter = (mag + DEC_W'(2)) >> 2;
    assign rounded = r_acc[DEC_W-1] ? -$signed(quarter) : $signed(quarter);

    assign d_neg = r_dec[DEC_W-1];
    assign d_pos = !r_dec[DEC_W-1] && (r_dec != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y  <= '0;
            r_r2 <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                mer_pkg::OP_LOAD: begin
                    r_y  <= i_radius_y;
                    r_r2 <= 1'b0;
                end
                mer_pkg::OP_R1_MOVE: begin
                    if (!d_neg) begin
                        r_y <= r_y - R'(1);
                    end
                end
                mer_pkg::OP_SQ_TX: begin
                    r_r2 <= 1'b1;
                end
                mer_pkg::OP_R2_MOVE: begin
                    r_y <= r_y - R'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_full;
        unique case (i_cmd.op)
            mer_pkg::OP_LOAD: begin
                r_cx <= i_center_x;
                r_cy <= i_center_y;
                r_rx <= i_radius_x;
                r_ry <= i_radius_y;
                r_x  <= '0;
                r_px <= '0;
            end
            mer_pkg::OP_SQ_RY:  r_rx2 <= r_prod[SQ_W-1:0];
            mer_pkg::OP_RX2_RY: r_ry2 <= r_prod[SQ_W-1:0];
            mer_pkg::OP_INIT1: begin
                r_py  <= py_init;
                r_acc <= init1_sum;
            end
            mer_pkg::OP_ROUND:  r_dec <= rounded;
            mer_pkg::OP_R1_MOVE: begin
                r_x  <= r_x + XW'(1);
                r_px <= r_px + ry2_x2;
                if (!d_neg) begin
                    r_py <= r_py - rx2_x2;
                end
            end
            mer_pkg::OP_R1_DEC: begin
                if (d_neg) begin
                    r_dec <= r_dec + ry2_d + px_d;
                end else begin
                    r_dec <= r_dec + ry2_d + px_d - py_d;
                end
            end
            mer_pkg::OP_SQ_TY:   r_acc <= prod_d;
            mer_pkg::OP_MUL_RR:  r_acc <= r_acc + prod_x4;
            mer_pkg::OP_ACC_SUB: r_acc <= r_acc - prod_x4;
            mer_pkg::OP_R2_MOVE: begin
                r_py <= r_py - rx2_x2;
                if (!d_pos) begin
                    r_x  <= r_x + XW'(1);
                    r_px <= r_px + ry2_x2;
                end
            end
            mer_pkg::OP_R2_DEC: begin
                if (d_pos) begin
                    r_dec <= r_dec + rx2_d - py_d;
                end else begin
                    r_dec <= r_dec + rx2_d - py_d + px_d;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_status.in_r1      = !r_r2 && (r_px < r_py);
    assign o_status.in_r2      = r_r2;
    assign o_status.shape_done = (r_y == '0);

    assign cx_s  = {{(SUM_W-COORD_BITS){r_cx[COORD_BITS-1]}}, r_cx};
    assign cy_s  = {{(SUM_W-COORD_BITS){r_cy[COORD_BITS-1]}}, r_cy};
    assign x_s   = {{(SUM_W-XW){1'b0}}, r_x};
    assign y_s   = {{(SUM_W-R){1'b0}}, r_y};
    assign sum_x = i_cmd.pt[0] ? (cx_s - x_s) : (cx_s + x_s);
    assign sum_y = i_cmd.pt[1] ? (cy_s - y_s) : (cy_s + y_s);

    assign o_pixel_x = sum_x[COORD_BITS:0];
    assign o_pixel_y = sum_y[COORD_BITS:0];

endmodule
`default_nettype wire

>>> hw/rtl/mer_ctrl.sv
// Controller of the ellipse rasterizer: sequences setup, iterations and point output.
`default_nettype none
module mer_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic                i_mode,
    output logic                     o_stall,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_last_of_step,
    output logic                     o_shape_finished,
    input  wire mer_pkg::t_dp_status i_status,
    output mer_pkg::t_dp_cmd         o_cmd
);

    mer_pkg::t_state r_state, n_state;
    logic [1:0]      r_pt, n_pt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mer_pkg::ST_IDLE;
            r_pt    <= '0;
        end else begin
            r_state <= n_state;
            r_pt    <= n_pt;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mer_pkg::ST_IDLE: begin
                if (i_valid) begin
                    // An advance request with no ellipse in progress is dropped.
                    priority if (!i_mode) begin
                        n_state = mer_pkg::ST_SQ_RX;
                    end else if (i_status.shape_done) begin
                        n_state = mer_pkg::ST_IDLE;
                    end else if (i_status.in_r1) begin
                        n_state = mer_pkg::ST_R1_MOVE;
                    end else if (!i_status.in_r2) begin
                        n_state = mer_pkg::ST_SQ_TX;
                    end else begin
                        n_state = mer_pkg::ST_R2_MOVE;
                    end
                end
            end
            mer_pkg::ST_SQ_RX:   n_state = mer_pkg::ST_SQ_RY;
            mer_pkg::ST_SQ_RY:   n_state = mer_pkg::ST_RX2_RY;
            mer_pkg::ST_RX2_RY:  n_state = mer_pkg::ST_INIT1;
            mer_pkg::ST_INIT1:   n_state = mer_pkg::ST_ROUND1;
            mer_pkg::ST_ROUND1:  n_state = mer_pkg::ST_EMIT;
            mer_pkg::ST_R1_MOVE: n_state = mer_pkg::ST_R1_DEC;
            mer_pkg::ST_R1_DEC:  n_state = mer_pkg::ST_EMIT;
            mer_pkg::ST_SQ_TX:   n_state = mer_pkg::ST_MUL_TX2;
            mer_pkg::ST_MUL_TX2: n_state = mer_pkg::ST_SQ_TY;
            mer_pkg::ST_SQ_TY:   n_state = mer_pkg::ST_MUL_TY2;
            mer_pkg::ST_MUL_TY2: n_state = mer_pkg::ST_MUL_RR;
            mer_pkg::ST_MUL_RR:  n_state = mer_pkg::ST_ACC_SUB;
            mer_pkg::ST_ACC_SUB: n_state = mer_pkg::ST_ROUND2;
            mer_pkg::ST_ROUND2:  n_state = mer_pkg::ST_R2_MOVE;
            mer_pkg::ST_R2_MOVE: n_state = mer_pkg::ST_R2_DEC;
            mer_pkg::ST_R2_DEC:  n_state = mer_pkg::ST_EMIT;
            mer_pkg::ST_EMIT: begin
                if (!i_stall && (r_pt == mer_pkg::LAST_PT)) begin
                    n_state = mer_pkg::ST_IDLE;
                end
            end
            default: n_state = mer_pkg::ST_IDLE;
        endcase
    end

    // The point index wraps back to zero after the fourth point.
    always_comb begin
        n_pt = r_pt;
        if ((r_state == mer_pkg::ST_EMIT) && !i_stall) begin
            n_pt = r_pt + 2'd1;
        end
    end

    always_comb begin
        o_cmd.pt = r_pt;
        unique case (r_state)
            mer_pkg::ST_IDLE: begin
                o_cmd.op = (i_valid && !i_mode) ? mer_pkg::OP_LOAD : mer_pkg::OP_NONE;
            end
            mer_pkg::ST_SQ_RX:   o_cmd.op = mer_pkg::OP_SQ_RX;
            mer_pkg::ST_SQ_RY:   o_cmd.op = mer_pkg::OP_SQ_RY;
            mer_pkg::ST_RX2_RY:  o_cmd.op = mer_pkg::OP_RX2_RY;
            mer_pkg::ST_INIT1:   o_cmd.op = mer_pkg::OP_INIT1;
            mer_pkg::ST_ROUND1:  o_cmd.op = mer_pkg::OP_ROUND;
            mer_pkg::ST_R1_MOVE: o_cmd.op = mer_pkg::OP_R1_MOVE;
            mer_pkg::ST_R1_DEC:  o_cmd.op = mer_pkg::OP_R1_DEC;
            mer_pkg::ST_SQ_TX:   o_cmd.op = mer_pkg::OP_SQ_TX;
            mer_pkg::ST_MUL_TX2: o_cmd.op = mer_pkg::OP_MUL_TX2;
            mer_pkg::ST_SQ_TY:   o_cmd.op = mer_pkg::OP_SQ_TY;
            mer_pkg::ST_MUL_TY2: o_cmd.op = mer_pkg::OP_MUL_TY2;
            mer_pkg::ST_MUL_RR:  o_cmd.op = mer_pkg::OP_MUL_RR;
            mer_pkg::ST_ACC_SUB: o_cmd.op = mer_pkg::OP_ACC_SUB;
            mer_pkg::ST_ROUND2:  o_cmd.op = mer_pkg::OP_ROUND;
            mer_pkg::ST_R2_MOVE: o_cmd.op = mer_pkg::OP_R2_MOVE;
            mer_pkg::ST_R2_DEC:  o_cmd.op = mer_pkg::OP_R2_DEC;
            default:             o_cmd.op = mer_pkg::OP_NONE;
        endcase
    end

    assign o_stall          = (r_state != mer_pkg::ST_IDLE);
    assign o_valid          = (r_state == mer_pkg::ST_EMIT);
    assign o_last_of_step   = (r_pt == mer_pkg::LAST_PT);
    assign o_shape_finished = (r_pt == mer_pkg::LAST_PT) && i_status.shape_done;

endmodule
`default_nettype wire

>>> hw/rtl/midpoint_ellipse_rasterizer_unit.sv
// Top level of the midpoint ellipse rasterizer.
// Usage:
//   Input channel (i_valid / o_stall) takes one request at a time. A request with
//   i_mode low starts a new ellipse from the center and radii fields; a request with
//   i_mode high advances the running ellipse by one midpoint iteration.
//   Output channel (o_valid / i_stall) gives four points per request, in the order
//   (+x,+y), (-x,+y), (+x,-y), (-x,-y); o_last_of_step marks the fourth, and
//   o_shape_finished also marks it when the ellipse has reached y equal to zero.
// Steps from the accepting edge to the first point, with one shared multiplier
// and one decision register doing the work:
//   a start request passes SQ_RX, SQ_RY, RX2_RY, INIT1 and ROUND1; a region-1
//   iteration passes R1_MOVE and R1_DEC, a region-2 iteration R2_MOVE and R2_DEC;
//   the first region-2 iteration recomputes the decision value before them through
//   five products (SQ_TX to MUL_RR), ACC_SUB and ROUND2. The four points then follow
//   in EMIT. An advance request with no ellipse running is taken and gives no points.
// o_stall is high while a request is in work or its points are being delivered.
// A stalled output holds its point unchanged until it is taken.
// Reset (synchronous, active low) returns to idle with no ellipse in progress.
`default_nettype none
`include "assert_macros.svh"
module midpoint_ellipse_rasterizer_unit #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_mode,
    input  wire logic signed [COORD_BITS-1:0]  i_center_x,
    input  wire logic signed [COORD_BITS-1:0]  i_center_y,
    input  wire logic        [RADIUS_BITS-1:0] i_radius_x,
    input  wire logic        [RADIUS_BITS-1:0] i_radius_y,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [COORD_BITS:0]         o_pixel_x,
    output logic signed [COORD_BITS:0]         o_pixel_y,
    output logic                               o_last_of_step,
    output logic                               o_shape_finished
);

    mer_pkg::t_dp_cmd    cmd;
    mer_pkg::t_dp_status status;

    mer_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_mode           (i_mode),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_last_of_step   (o_last_of_step),
        .o_shape_finished (o_shape_finished),
        .i_status         (status),
        .o_cmd            (cmd)
    );

    mer_datapath #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius_x (i_radius_x),
        .i_radius_y (i_radius_y),
        .o_status   (status),
        .o_pixel_x  (o_pixel_x),
        .o_pixel_y  (o_pixel_y)
    );

    // Points are only delivered while no new request can enter.
    `MER_ASSERT_NOW(a_valid_blocks_input, i_clk, i_rst_n, o_valid, o_stall)

    // A finished shape is only flagged on the closing point of a step.
    `MER_ASSERT_NOW(a_finish_on_last, i_clk, i_rst_n, o_valid && o_shape_finished,
        o_last_of_step)

    // After the closing point is taken, the block returns to idle.
    `MER_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n,
        o_valid && !i_stall && o_last_of_step, !o_valid && !o_stall)

    // A start request always keeps the block busy in the next cycle.
    `MER_ASSERT_NEXT(a_start_goes_busy, i_clk, i_rst_n, i_valid && !o_stall && !i_mode,
        o_stall && !o_valid)

endmodule
`default_nettype wire

>>> tb/ellipse_point_checker.sv
// Request codes and the checker that predicts and compares the rasterizer's points.
package ellipse_tb_pkg;

    typedef enum bit {
        MODE_START   = 1'b0,
        MODE_ADVANCE = 1'b1
    } ellipse_mode_e;

endpackage

module ellipse_point_checker #(
    parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    input  logic                          i_req_stall,
    input  logic                          i_mode,
    input  logic signed [COORD_BITS-1:0]  i_center_x,
    input  logic signed [COORD_BITS-1:0]  i_center_y,
    input  logic        [RADIUS_BITS-1:0] i_radius_x,
    input  logic        [RADIUS_BITS-1:0] i_radius_y,
    input  logic                          i_pt_valid,
    input  logic                          i_pt_stall,
    input  logic signed [COORD_BITS:0]    i_pixel_x,
    input  logic signed [COORD_BITS:0]    i_pixel_y,
    input  logic                          i_last_of_step,
    input  logic                          i_shape_finished,
    output int                            o_error_count,
    output int                            o_pending
);
    import ellipse_tb_pkg::*;

    typedef struct packed {
        logic signed [COORD_BITS:0] x;
        logic signed [COORD_BITS:0] y;
        logic                       last;
        logic                       finished;
    } point_t;

    point_t expected_points[$];

    // Shadow copy of the rasterizer's walk.
    logic signed [COORD_BITS-1:0] org_x, org_y;
    longint rx_sq, ry_sq;
    longint walk_x, walk_y;
    longint slope_x, slope_y;
    longint decision;
    bit     in_region_two;
    bit     running;

    initial begin
        org_x = '0;
        org_y = '0;
        rx_sq = 0;
        ry_sq = 0;
        walk_x = 0;
        walk_y = 0;
        slope_x = 0;
        slope_y = 0;
        decision = 0;
        in_region_two = 1'b0;
        running = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        o_error_count++;
    endtask

    // Quarter of n, rounded to nearest with halves away from zero.
    function automatic longint quarter_round(input longint n);
        if (n >= 0)
            return (n + 2) / 4;
        return -((-n + 2) / 4);
    endfunction

    task automatic push_quadrants(input bit finishes);
        point_t p;
        for (int k = 0; k < 4; k++) begin
            p.x = (k & 1) ? org_x - walk_x : org_x + walk_x;
            p.y = (k & 2) ? org_y - walk_y : org_y + walk_y;
            p.last = (k == 3);
            p.finished = (k == 3) && finishes;
            expected_points.push_back(p);
        end
    endtask

    task automatic trace_ellipse_step(
        input ellipse_mode_e                   mode,
        input logic signed [COORD_BITS-1:0]    cx,
        input logic signed [COORD_BITS-1:0]    cy,
        input logic        [RADIUS_BITS-1:0]   rx,
        input logic        [RADIUS_BITS-1:0]   ry
    );
        longint rxl, ryl, tx, ty;
        if (mode == MODE_START) begin
            rxl = rx;
            ryl = ry;
            org_x = cx;
            org_y = cy;
            rx_sq = rxl * rxl;
            ry_sq = ryl * ryl;
            walk_x = 0;
            walk_y = ryl;
            slope_x = 0;
            slope_y = 2 * rx_sq * ryl;
            decision = quarter_round(4 * ry_sq - 4 * rx_sq * ryl + rx_sq);
            in_region_two = 1'b0;
            running = (walk_y != 0);
            push_quadrants(!running);
        end else if (running) begin
            if (!in_region_two && slope_x < slope_y) begin
                walk_x++;
                slope_x += 2 * ry_sq;
                if (decision < 0) begin
                    decision += ry_sq + slope_x;
                end else begin
                    walk_y--;
                    slope_y -= 2 * rx_sq;
                    decision += ry_sq + slope_x - slope_y;
                end
            end else begin
                // The region-2 decision is rebuilt from the current point once.
                if (!in_region_two) begin
                    tx = 2 * walk_x + 1;
                    ty = walk_y - 1;
                    in_region_two = 1'b1;
                    decision = quarter_round(ry_sq * tx * tx + 4 * rx_sq * ty * ty
                                             - 4 * rx_sq * ry_sq);
                end
                walk_y--;
                slope_y -= 2 * rx_sq;
                if (decision > 0) begin
                    decision += rx_sq - slope_y;
                end else begin
                    walk_x++;
                    slope_x += 2 * ry_sq;
                    decision += rx_sq - slope_y + slope_x;
                end
            end
            running = (walk_y != 0);
            push_quadrants(!running);
        end
    endtask

    always @(posedge i_clk) begin
        point_t want;
        if (i_rst_n) begin
            if ($isunknown({i_req_stall, i_pt_valid}))
                report_mismatch("handshake output is unknown");
            if (i_req_valid && !i_req_stall)
                trace_ellipse_step(ellipse_mode_e'(i_mode), i_center_x, i_center_y,
                                   i_radius_x, i_radius_y);
            if (i_pt_valid && !i_pt_stall) begin
                if (expected_points.size() == 0) begin
                    report_mismatch($sformatf("unexpected point x=%0d y=%0d",
                                              i_pixel_x, i_pixel_y));
                end else begin
                    want = expected_points.pop_front();
                    if (i_pixel_x !== want.x || i_pixel_y !== want.y ||
                        i_last_of_step !== want.last || i_shape_finished !== want.finished)
                        report_mismatch($sformatf(
                            "got x=%0d y=%0d last=%0b fin=%0b, want x=%0d y=%0d last=%0b fin=%0b",
                            i_pixel_x, i_pixel_y, i_last_of_step, i_shape_finished,
                            want.x, want.y, want.last, want.finished));
                end
            end
        end
        o_pending <= expected_points.size();
    end

endmodule

>>> tb/tb.sv
// Testbench top: drives requests into the ellipse rasterizer and gives the verdict.
module tb;
    import ellipse_tb_pkg::*;

    localparam int COORD_BITS  = mer_pkg::COORD_BITS_DEF;
    localparam int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_ITEMS = 200;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    logic                          req_mode = 1'b0;
    logic signed [COORD_BITS-1:0]  req_center_x = '0;
    logic signed [COORD_BITS-1:0]  req_center_y = '0;
    logic        [RADIUS_BITS-1:0] req_radius_x = '0;
    logic        [RADIUS_BITS-1:0] req_radius_y = '0;
    logic                          pt_valid;
    logic                          pt_stall = 1'b0;
    logic signed [COORD_BITS:0]    pt_x;
    logic signed [COORD_BITS:0]    pt_y;
    logic                          pt_last;
    logic                          pt_finished;

    int error_count;
    int pending_points;
    int items_sent = 0;
    int cycle_count = 0;
    bit held_off = 1'b0;

    midpoint_ellipse_rasterizer_unit #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (req_valid),
        .o_stall          (req_stall),
        .i_mode           (req_mode),
        .i_center_x       (req_center_x),
        .i_center_y       (req_center_y),
        .i_radius_x       (req_radius_x),
        .i_radius_y       (req_radius_y),
        .o_valid          (pt_valid),
        .i_stall          (pt_stall),
        .o_pixel_x        (pt_x),
        .o_pixel_y        (pt_y),
        .o_last_of_step   (pt_last),
        .o_shape_finished (pt_finished)
    );

    ellipse_point_checker #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_req_valid      (req_valid),
        .i_req_stall      (req_stall),
        .i_mode           (req_mode),
        .i_center_x       (req_center_x),
        .i_center_y       (req_center_y),
        .i_radius_x       (req_radius_x),
        .i_radius_y       (req_radius_y),
        .i_pt_valid       (pt_valid),
        .i_pt_stall       (pt_stall),
        .i_pixel_x        (pt_x),
        .i_pixel_y        (pt_y),
        .i_last_of_step   (pt_last),
        .i_shape_finished (pt_finished),
        .o_error_count    (error_count),
        .o_pending        (pending_points)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[midpoint_ellipse_rasterizer_unit] ERROR");
            $finish;
        end
    end

    // A stretch of the random part where neither side pauses.
    function automatic bit no_idle();
        return items_sent >= 30 && items_sent < 70;
    endfunction

    // Point receiver: random stalls, plus one long hold-off so the block backs up.
    initial begin
        forever begin
            @(posedge clk);
            if (!held_off && items_sent >= 90) begin
                held_off = 1'b1;
                pt_stall <= 1'b1;
                for (int n = 0; n < 300; n++)
                    @(posedge clk);
            end else begin
                pt_stall <= !no_idle() && ($urandom_range(0, 99) < 35);
            end
        end
    end

    task automatic send_request(
        input ellipse_mode_e                 mode,
        input logic signed [COORD_BITS-1:0]  cx,
        input logic signed [COORD_BITS-1:0]  cy,
        input logic        [RADIUS_BITS-1:0] rx,
        input logic        [RADIUS_BITS-1:0] ry
    );
        int gap;
        gap = 0;
        if (!no_idle() && $urandom_range(0, 99) < 35)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_mode <= mode;
        req_center_x <= cx;
        req_center_y <= cy;
        req_radius_x <= rx;
        req_radius_y <= ry;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // One start request followed by advance requests carrying junk in the unused fields.
    task automatic trace_shape(
        input logic signed [COORD_BITS-1:0]  cx,
        input logic signed [COORD_BITS-1:0]  cy,
        input logic        [RADIUS_BITS-1:0] rx,
        input logic        [RADIUS_BITS-1:0] ry,
        input int                            n_advance
    );
        send_request(MODE_START, cx, cy, rx, ry);
        repeat (n_advance)
            send_request(MODE_ADVANCE, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial begin
        int pick;
        logic [RADIUS_BITS-1:0] rx, ry;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Advance with nothing running, then degenerate and extreme shapes.
        send_request(MODE_ADVANCE, $urandom, $urandom, $urandom, $urandom);
        trace_shape(0, 0, 0, 0, 1);
        trace_shape(2047, -2048, 1023, 1023, 2);
        // The next two starts each abandon the shape still in progress.
        trace_shape(-2048, 2047, 1023, 1, 2);
        trace_shape(-2048, 2047, 0, 3, 4);
        trace_shape(100, -100, 5, 0, 1);
        trace_shape(-1, 1, 4, 2, 7);

        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // Complete shapes, mostly small, sometimes with advances past the end.
                rx = (pick < 5) ? $urandom_range(0, 30) : $urandom_range(0, 12);
                ry = (pick < 5) ? $urandom_range(0, 30) : $urandom_range(0, 12);
                trace_shape($urandom, $urandom, rx, ry, rx + ry + $urandom_range(0, 2));
            end else if (pick < 88) begin
                trace_shape($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 5));
            end else begin
                send_request(ellipse_mode_e'($urandom_range(0, 1)),
                             $urandom, $urandom, $urandom, $urandom);
            end
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (pending_points != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0 && pending_points == 0)
            $display("[midpoint_ellipse_rasterizer_unit] OK");
        else
            $display("[midpoint_ellipse_rasterizer_unit] ERROR");
        $finish;
    end

endmodule
